>>> sv/calendar_add_seconds_top_defines.svh
// Assertion macros shared by the calendar add-seconds checker.
// No dependencies; take in with `include inside a module body.
`ifndef CALENDAR_ADD_SECONDS_TOP_DEFINES_SVH
`define CALENDAR_ADD_SECONDS_TOP_DEFINES_SVH

// A stalled signal holds its value into the next cycle
`define CAS_ASSERT_STABLE(lbl, clk, rst_n, cond, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("signal changed while stalled");

// Consequent holds in the same cycle
`define CAS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Consequent holds in the following cycle
`define CAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> sv/cas_pkg.sv
// Package for the calendar add-seconds block: item structs, working state,
// sequencer states, calendar constants and the month-length function.
package cas_pkg;

    // Width of the seconds-to-add field
    localparam int CAS_ADD_WIDTH = 20;

    localparam logic [5:0] SEC_PER_MIN     = 6'd60;
    localparam logic [5:0] MIN_PER_HOUR    = 6'd60;
    localparam logic [4:0] HOUR_PER_DAY    = 5'd24;
    localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [6:0] YEAR_MAX        = 7'd99;
    // Year offset of 2100: the only century in range that is not a leap
    // year (2000 is divisible by 400, so it is)
    localparam logic [6:0] YEAR_NO_LEAP_CENTURY = 7'd100;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    typedef logic [CAS_ADD_WIDTH-1:0] t_cas_left;

    typedef struct packed {
        logic [6:0] start_year;
        logic [3:0] start_month;
        logic [4:0] start_day;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [5:0] start_second;
        logic [2:0] start_weekday;
        t_cas_left  add_seconds;
    } t_cas_in;

    typedef struct packed {
        logic [6:0] new_year;
        logic [3:0] new_month;
        logic [4:0] new_day;
        logic [4:0] new_hour;
        logic [5:0] new_minute;
        logic [5:0] new_second;
        logic [2:0] new_weekday;
    } t_cas_out;

    // Date and time being advanced, with the seconds still to add
    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
        t_cas_left  left;
    } t_cas_work;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_cas_state;

    // Days in a month; months outside 1..12 count as 31 days.
    // Leap rule of (2000 + year) over offsets 0..127: multiple of four,
    // except 2100.
    function automatic logic [4:0] cas_month_days(input logic [6:0] year,
                                                  input logic [3:0] month);
        logic leap;
        begin
            leap = (year[1:0] == 2'b00) && (year != YEAR_NO_LEAP_CENTURY);
            case (month)
                MONTH_FEB: return leap ? 5'd29 : 5'd28;
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 5'd30;
                default: return 5'd31;
            endcase
        end
    endfunction

endpackage

>>> sv/cas_step.sv
// One step of the date advance: finish the seconds, or move to the next
// minute and ripple the carry up to the year. Depends on cas_pkg.
module cas_step (
    input  cas_pkg::t_cas_work i_work,
    output cas_pkg::t_cas_work o_work
);
    import cas_pkg::*;

    logic [5:0] to_next;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [5:0] day_inc;
    logic [4:0] month_inc;
    logic [7:0] year_inc;
    logic [4:0] mdays;

    // Increment candidates and the seconds to the next minute boundary
    always_comb begin
        to_next   = (i_work.second < SEC_PER_MIN) ? (SEC_PER_MIN - i_work.second) : 6'd1;
        min_inc   = {1'b0, i_work.minute} + 7'd1;
        hour_inc  = {1'b0, i_work.hour} + 6'd1;
        day_inc   = {1'b0, i_work.day} + 6'd1;
        month_inc = {1'b0, i_work.month} + 5'd1;
        year_inc  = {1'b0, i_work.year} + 8'd1;
        mdays     = cas_month_days(i_work.year, i_work.month);
    end

    // Advance one step
    always_comb begin
        o_work = i_work;
        if (i_work.left < t_cas_left'(to_next)) begin
            // remainder fits within this minute
            o_work.second = i_work.second + i_work.left[5:0];
            o_work.left   = '0;
        end else begin
            o_work.left   = i_work.left - t_cas_left'(to_next);
            o_work.second = '0;
            if (min_inc < {1'b0, MIN_PER_HOUR}) begin
                o_work.minute = min_inc[5:0];
            end else begin
                o_work.minute = '0;
                if (hour_inc < {1'b0, HOUR_PER_DAY}) begin
                    o_work.hour = hour_inc[4:0];
                end else begin
                    o_work.hour = '0;
                    if (day_inc <= {1'b0, mdays}) begin
                        o_work.day = day_inc[4:0];
                    end else begin
                        o_work.day = 5'd1;
                        if (month_inc <= {1'b0, MONTHS_PER_YEAR}) begin
                            o_work.month = month_inc[3:0];
                        end else begin
                            o_work.month = 4'd1;
                            o_work.year  = (year_inc > {1'b0, YEAR_MAX}) ?
                                           7'd0 : year_inc[6:0];
                        end
                    end
                end
            end
        end
    end

endmodule

>>> sv/calendar_add_seconds_top.sv
// Calendar add-seconds block: adds a count of seconds to a Gregorian date
// and time (year as offset from 2000, wrapping after 99) and returns one
// result item per input item, weekday copied through. The block works on
// one item at a time: a single step unit advances the time by at most one
// minute boundary per cycle; an item goes through a load, the steps, an
// end check and a hand-off to the output register. The input side is
// ready again as soon as the result sits in the output register, even if
// that is not yet taken. Depends on cas_pkg and cas_step.
module calendar_add_seconds_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cas_pkg::t_cas_in i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output cas_pkg::t_cas_out o_out_data
);
    import cas_pkg::*;

    t_cas_state r_state, n_state;
    t_cas_work  r_work, n_work;
    t_cas_work  step_work;
    t_cas_out   r_out, n_out;
    logic       r_out_valid, n_out_valid;
    logic       in_take;
    logic       out_load;

    cas_step u_step (
        .i_work (r_work),
        .o_work (step_work)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_work.left == '0) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_RUN:  o_in_ready = 1'b0;
            ST_DONE: out_load   = !r_out_valid || i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign in_take = i_in_valid && o_in_ready;

    // Load an item, step it, or hold
    always_comb begin
        n_work = r_work;
        if (in_take) begin
            n_work.year    = i_in_data.start_year;
            n_work.month   = i_in_data.start_month;
            n_work.day     = i_in_data.start_day;
            n_work.hour    = i_in_data.start_hour;
            n_work.minute  = i_in_data.start_minute;
            n_work.second  = i_in_data.start_second;
            n_work.weekday = i_in_data.start_weekday;
            n_work.left    = i_in_data.add_seconds;
        end else if (r_state == ST_RUN && r_work.left != '0) begin
            n_work = step_work;
        end
    end

    // Output register: fill from the finished item, drop once taken
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out.new_year    = r_work.year;
            n_out.new_month   = r_work.month;
            n_out.new_day     = r_work.day;
            n_out.new_hour    = r_work.hour;
            n_out.new_minute  = r_work.minute;
            n_out.new_second  = r_work.second;
            n_out.new_weekday = r_work.weekday;
            n_out_valid       = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/cas_checker.sv
// Port-level checker for the calendar add-seconds block, bound to the top.
// Depends on cas_pkg and calendar_add_seconds_top_defines.svh.
module cas_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input cas_pkg::t_cas_out o_out_data
);
    import cas_pkg::*;
    `include "calendar_add_seconds_top_defines.svh"

    logic in_take;
    logic out_stall;

    assign in_take   = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    // A waiting result item holds
    `CAS_ASSERT_STABLE(a_out_hold, i_clk, i_rst_n, out_stall, o_out_data)
    // Busy in the cycle after taking an item
    `CAS_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, in_take, !o_in_ready)
    // A new result only appears as a finished item leaves the busy phase
    `CAS_ASSERT_IMPL(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $rose(o_in_ready))

endmodule

bind calendar_add_seconds_top cas_checker u_cas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> verif/tb_calendar_add_seconds_top.sv
// Self-checking testbench for calendar_add_seconds_top: date and time items
// in, advanced date and time items out, each checked against a local model.
// Depends on cas_pkg for the item structs; needs no files or arguments.
module tb_calendar_add_seconds_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cas_pkg::*;

    // Watchdog limit, several times what a full-range item takes
    localparam int STALL_LIMIT   = 80000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_LINES  = 40;
    localparam int RANDOM_ITEMS  = 55;
    localparam int QUIET_ITEMS   = 20;
    localparam int IN_BITS       = $bits(t_cas_in);

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_cas_in  i_in_data   = '0;
    logic     i_out_ready = 1'b1;
    logic     o_in_ready;
    logic     o_out_valid;
    t_cas_out o_out_data;

    t_cas_out pending_dates[$];
    int       items_sent     = 0;
    int       directed_items = 0;
    int       dates_checked  = 0;
    int       mismatch_count = 0;
    bit       idle_on        = 1'b1;

    calendar_add_seconds_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Gregorian month length on (2000 + year); every other month, including
    // those outside 1..12, counts as 31 days
    function automatic int unsigned month_length(int unsigned year, int unsigned month);
        int unsigned full_year;
        bit          is_leap;
        full_year = 2000 + year;
        is_leap = ((full_year % 4 == 0) && (full_year % 100 != 0)) || (full_year % 400 == 0);
        case (month)
            2:           return is_leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Advance the date one minute boundary at a time, carrying upwards
    function automatic t_cas_out advance_calendar(t_cas_in item);
        int unsigned year, month, day, hour, minute, second, left, to_next;
        t_cas_out    res;
        year   = 32'(item.start_year);
        month  = 32'(item.start_month);
        day    = 32'(item.start_day);
        hour   = 32'(item.start_hour);
        minute = 32'(item.start_minute);
        second = 32'(item.start_second);
        left   = 32'(item.add_seconds);
        while (left > 0) begin
            to_next = (second < 60) ? 60 - second : 1;
            if (left < to_next) begin
                second += left;
                left = 0;
            end else begin
                left -= to_next;
                second = 0;
                minute++;
                if (minute >= 60) begin
                    minute = 0;
                    hour++;
                    if (hour >= 24) begin
                        hour = 0;
                        day++;
                        if (day > month_length(year, month)) begin
                            day = 1;
                            month++;
                            if (month > 12) begin
                                month = 1;
                                year++;
                                if (year > 99) year = 0;
                            end
                        end
                    end
                end
            end
        end
        res.new_year    = 7'(year);
        res.new_month   = 4'(month);
        res.new_day     = 5'(day);
        res.new_hour    = 5'(hour);
        res.new_minute  = 6'(minute);
        res.new_second  = 6'(second);
        res.new_weekday = item.start_weekday;
        return res;
    endfunction

    function automatic t_cas_in make_item(int unsigned year, int unsigned month,
                                          int unsigned day, int unsigned hour,
                                          int unsigned minute, int unsigned second,
                                          int unsigned weekday, int unsigned add);
        t_cas_in item;
        item.start_year    = 7'(year);
        item.start_month   = 4'(month);
        item.start_day     = 5'(day);
        item.start_hour    = 5'(hour);
        item.start_minute  = 6'(minute);
        item.start_second  = 6'(second);
        item.start_weekday = 3'(weekday);
        item.add_seconds   = t_cas_left'(add);
        return item;
    endfunction

    // Keep most counts short; only a few span the full field
    function automatic int unsigned random_add_count();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) return $urandom_range(0, 4095);
        if (pick < 17) return $urandom_range(0, 65535);
        return $urandom_range(0, (1 << CAS_ADD_WIDTH) - 1);
    endfunction

    // Valid dates, leaning towards the ends of minutes, days, months and years
    function automatic t_cas_in random_valid_item();
        int unsigned year, month, day, hour, minute, second, len;
        year   = ($urandom_range(0, 3) == 0) ? 99 : $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       month = 12;
            1:       month = 2;
            default: month = $urandom_range(1, 12);
        endcase
        len    = month_length(year, month);
        day    = $urandom_range(0, 1) ? len - $urandom_range(0, 1) : $urandom_range(1, len);
        hour   = $urandom_range(0, 1) ? 23 : $urandom_range(0, 23);
        minute = $urandom_range(0, 1) ? 59 : $urandom_range(0, 59);
        second = $urandom_range(0, 1) ? 59 - $urandom_range(0, 3) : $urandom_range(0, 59);
        return make_item(year, month, day, hour, minute, second, $urandom_range(0, 7),
                         random_add_count());
    endfunction

    // Any bit pattern at all in the date fields
    function automatic t_cas_in random_raw_item();
        logic [IN_BITS-1:0] raw;
        t_cas_in            item;
        raw = IN_BITS'({$urandom, $urandom});
        item = raw;
        item.add_seconds = t_cas_left'(random_add_count());
        return item;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < REPORT_LINES) $display("[%0t] MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                      dates_checked, name, got, want));
    endtask

    // Present one item, hold it until taken, and record its expected result
    task automatic send_date(t_cas_in item);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        pending_dates.push_back(advance_calendar(item));
        items_sent++;
    endtask

    // Hold off the sender until every expected result is back
    task automatic wait_all_dates_back();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_dates.size() != 0);
    endtask

    task automatic test_zero_add();
        send_date(make_item(24, 2, 29, 12, 30, 30, 3, 0));
        send_date(make_item(127, 15, 31, 31, 63, 63, 7, 0));
    endtask

    task automatic test_field_extremes();
        send_date(make_item(0, 1, 1, 0, 0, 0, 0, 1));
        send_date(make_item(99, 12, 31, 23, 59, 59, 7, 1));
        send_date(make_item(0, 1, 1, 0, 0, 0, 5, 59));
        send_date(make_item(10, 6, 15, 10, 20, 1, 1, 60));
        send_date(make_item(50, 3, 10, 0, 0, 0, 2, 3600));
        send_date(make_item(50, 3, 10, 0, 0, 0, 2, 86400));
        send_date(make_item(0, 1, 1, 0, 0, 0, 6, (1 << CAS_ADD_WIDTH) - 1));
        send_date(make_item(98, 12, 25, 7, 13, 42, 4, (1 << CAS_ADD_WIDTH) - 1));
    endtask

    task automatic test_month_rollover();
        send_date(make_item(23, 8, 31, 23, 59, 59, 1, 1));
        send_date(make_item(0, 2, 28, 23, 59, 59, 2, 1));
        send_date(make_item(4, 2, 29, 23, 59, 59, 2, 1));
        send_date(make_item(100, 2, 28, 23, 59, 59, 2, 1));
        send_date(make_item(23, 4, 30, 23, 59, 59, 2, 1));
        send_date(make_item(23, 12, 31, 23, 59, 59, 2, 1));
        send_date(make_item(23, 11, 30, 23, 59, 59, 2, 1));
    endtask

    task automatic test_out_of_range_fields();
        send_date(make_item(23, 5, 5, 5, 5, 63, 0, 1));
        send_date(make_item(23, 5, 5, 5, 63, 59, 0, 1));
        send_date(make_item(23, 5, 5, 31, 59, 59, 0, 1));
        send_date(make_item(23, 5, 0, 23, 59, 59, 0, 1));
        send_date(make_item(23, 2, 31, 23, 59, 59, 0, 1));
        send_date(make_item(23, 0, 31, 23, 59, 59, 0, 1));
        send_date(make_item(23, 15, 31, 23, 59, 59, 0, 1));
        send_date(make_item(127, 12, 31, 23, 59, 59, 0, 1));
    endtask

    // Mostly valid dates, a quarter raw noise; drain once half way through
    task automatic test_random_traffic(int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) wait_all_dates_back();
            if ($urandom_range(0, 3) == 0) send_date(random_raw_item());
            else send_date(random_valid_item());
        end
    endtask

    // Drop the output ready in random bursts while idling is allowed
    initial begin : drive_out_ready
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_cas_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_dates.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          dates_checked));
            end else begin
                want = pending_dates.pop_front();
                check_field("year",    32'(o_out_data.new_year),    32'(want.new_year));
                check_field("month",   32'(o_out_data.new_month),   32'(want.new_month));
                check_field("day",     32'(o_out_data.new_day),     32'(want.new_day));
                check_field("hour",    32'(o_out_data.new_hour),    32'(want.new_hour));
                check_field("minute",  32'(o_out_data.new_minute),  32'(want.new_minute));
                check_field("second",  32'(o_out_data.new_second),  32'(want.new_second));
                check_field("weekday", 32'(o_out_data.new_weekday), 32'(want.new_weekday));
            end
            dates_checked++;
        end
    end

    // End the run when nothing moves on either side for too long
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("calendar_add_seconds_top test failed");
                $finish;
            end
        end
    end

    initial begin : run_tests
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_add();
        test_field_extremes();
        test_month_rollover();
        test_out_of_range_fields();
        directed_items = items_sent;
        test_random_traffic(RANDOM_ITEMS);

        // Finish with back-to-back traffic on both sides
        idle_on = 1'b0;
        test_random_traffic(QUIET_ITEMS);

        wait_all_dates_back();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        foreach (pending_dates[k])
            report_mismatch($sformatf("expected result %0d never arrived", k));

        $display("Ran %0d items (%0d directed: zero adds, field extremes, month and year",
                 items_sent, directed_items);
        $display("rollover, out-of-range fields), %0d results checked, %0d mismatches",
                 dates_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("calendar_add_seconds_top test passed");
        end else begin
            $display("calendar_add_seconds_top test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/cas_pkg.sv
sv/cas_step.sv
sv/calendar_add_seconds_top.sv
sv/cas_checker.sv
verif/tb_calendar_add_seconds_top.sv
